### rtl/ffa_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ffa_pkg: shared types and constants for the first-fit node allocator
// Request and response payloads, controller states, command/status bundles.
// -----------------------------------------------------------------------------
package ffa_pkg;

	localparam int NODES     = 3;
	localparam int MAX_CORES = 64;
	localparam int MAP_W     = 64;   // bitmap width of every node
	localparam int CNT_W     = 7;    // core count width
	localparam int NODE_W    = 2;    // node number width
	localparam int CHUNK     = 8;    // bits per count chunk
	localparam int CHUNKS    = MAP_W / CHUNK;
	localparam int CHUNK_CW  = $clog2(CHUNK + 1);
	localparam int LOC_W     = $clog2(CHUNK);

	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef struct packed {
		logic              opcode;
		logic [CNT_W-1:0]  req_cores;
		logic              req_accel;
		logic [NODE_W-1:0] release_node;
		logic [MAP_W-1:0]  release_mask;
		logic              release_accel;
	} ffa_req_t;

	typedef struct packed {
		logic              granted;
		logic [NODE_W-1:0] grant_node;
		logic [MAP_W-1:0]  grant_mask;
		logic [CNT_W-1:0]  free_count;
	} ffa_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REL,
		ST_CNT,
		ST_SUM,
		ST_EVAL
	} ffa_state_t;

	typedef struct packed {
		logic capture;    // latch request, rewind node pointer
		logic apply_rel;  // apply release, emit result
		logic count;      // per-chunk counts of current node
		logic sum;        // chunk prefix sums and total
		logic eval;       // decide, commit, maybe emit
		logic next_node;  // advance node pointer
	} ffa_cmd_t;

	typedef struct packed {
		logic qualify;
		logic last_node;
	} ffa_status_t;

	// Usable-core mask; counts above MAX_CORES saturate.
	function automatic logic [MAP_W-1:0] usable_mask(input logic [CNT_W-1:0] n);
		logic [MAP_W-1:0] m;
		m = '0;
		for (int i = 0; i < MAP_W; i++) begin
			m[i] = (CNT_W'(i) < n) && (i < MAX_CORES);
		end
		return m;
	endfunction

endpackage

### rtl/ffa_ctrl.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ffa_ctrl: allocator sequencer
// Walks release and per-node count/sum/evaluate steps, drives datapath commands.
// -----------------------------------------------------------------------------
module ffa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                opcode,
	input  ffa_pkg::ffa_status_t status,
	output ffa_pkg::ffa_cmd_t    cmd,
	output logic                busy
);
	import ffa_pkg::*;

	ffa_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = (opcode == OP_RELEASE) ? ST_REL : ST_CNT;
				end
			end
			ST_REL: begin
				cmd.apply_rel = 1'b1;
				state_d       = ST_IDLE;
			end
			ST_CNT: begin
				cmd.count = 1'b1;
				state_d   = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				if (status.qualify || status.last_node) begin
					state_d = ST_IDLE;
				end else begin
					cmd.next_node = 1'b1;
					state_d       = ST_CNT;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

### rtl/ffa_datapath.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ffa_datapath: busy stores, free-core counting and lowest-bit selection
// Holds node bitmaps and accelerator flags, the config register and the result.
// -----------------------------------------------------------------------------
module ffa_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ffa_pkg::ffa_req_t           req,
	input  logic                        cfg_we,
	input  logic [ffa_pkg::CNT_W-1:0]   cfg_wdata,
	input  ffa_pkg::ffa_cmd_t           cmd,
	output ffa_pkg::ffa_status_t        status,
	output logic                        done,
	output ffa_pkg::ffa_rsp_t           rsp
);
	import ffa_pkg::*;

	logic [MAP_W-1:0]  usable_q;
	logic [MAP_W-1:0]  busy_q [NODES];
	logic [NODES-1:0]  accel_q;
	ffa_req_t          req_q;
	logic [NODE_W-1:0] node_q;
	logic              done_q;
	ffa_rsp_t          rsp_q;

	// scan pipeline registers
	logic [MAP_W-1:0]    free_s1;
	logic [LOC_W-1:0]    loc_s1 [MAP_W];
	logic [CHUNK_CW-1:0] cnt_s1 [CHUNKS];
	logic [CNT_W-1:0]    pre_s2 [CHUNKS];
	logic [CNT_W-1:0]    avail_s2;

	logic [MAP_W-1:0]    free_d;
	logic [LOC_W-1:0]    loc_d [MAP_W];
	logic [CHUNK_CW-1:0] cnt_d [CHUNKS];
	logic [CNT_W-1:0]    pre_d [CHUNKS];
	logic [CNT_W-1:0]    avail_d;
	logic [MAP_W-1:0]    mask_d;
	logic                blocked;
	logic                qualify;
	logic                last_node;
	logic                rel_ok;

	// count stage: free bits, per-chunk counts and in-chunk rank
	always_comb begin
		logic [CHUNK_CW-1:0] run;
		free_d = ~busy_q[node_q] & usable_q;
		for (int c = 0; c < CHUNKS; c++) begin
			run = '0;
			for (int j = 0; j < CHUNK; j++) begin
				loc_d[c*CHUNK+j] = run[LOC_W-1:0];
				run = run + CHUNK_CW'(free_d[c*CHUNK+j]);
			end
			cnt_d[c] = run;
		end
	end

	// sum stage: chunk prefix counts
	always_comb begin
		pre_d[0] = '0;
		for (int c = 1; c < CHUNKS; c++) begin
			pre_d[c] = pre_d[c-1] + CNT_W'(cnt_s1[c-1]);
		end
		avail_d = pre_d[CHUNKS-1] + CNT_W'(cnt_s1[CHUNKS-1]);
	end

	// evaluate stage: qualify and pick lowest free cores
	always_comb begin
		blocked   = req_q.req_accel && accel_q[node_q];
		qualify   = !blocked && (req_q.req_cores != '0) && (avail_s2 >= req_q.req_cores);
		last_node = (node_q == NODE_W'(NODES - 1));
		rel_ok    = ({1'b0, req_q.release_node} < (NODE_W + 1)'(NODES));
		for (int i = 0; i < MAP_W; i++) begin
			mask_d[i] = free_s1[i] &&
				(({1'b0, pre_s2[i/CHUNK]} + (CNT_W + 1)'(loc_s1[i])) <
				 {1'b0, req_q.req_cores});
		end
	end

	assign status.qualify   = qualify;
	assign status.last_node = last_node;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			usable_q <= '1;
			accel_q  <= '0;
			node_q   <= '0;
			done_q   <= 1'b0;
			for (int n = 0; n < NODES; n++) begin
				busy_q[n] <= '0;
			end
		end else begin
			if (cfg_we) begin
				usable_q <= usable_mask(cfg_wdata);
			end
			if (cmd.capture) begin
				node_q <= '0;
			end else if (cmd.next_node) begin
				node_q <= node_q + 1'b1;
			end
			done_q <= cmd.apply_rel || (cmd.eval && (qualify || last_node));
			for (int n = 0; n < NODES; n++) begin
				if (cmd.apply_rel && (req_q.release_node == NODE_W'(n))) begin
					busy_q[n] <= busy_q[n] & ~req_q.release_mask;
					if (req_q.release_accel) begin
						accel_q[n] <= 1'b0;
					end
				end
				if (cmd.eval && qualify && (node_q == NODE_W'(n))) begin
					busy_q[n] <= busy_q[n] | mask_d;
					if (req_q.req_accel) begin
						accel_q[n] <= 1'b1;
					end
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
		if (cmd.count) begin
			free_s1 <= free_d;
			loc_s1  <= loc_d;
			cnt_s1  <= cnt_d;
		end
		if (cmd.sum) begin
			pre_s2   <= pre_d;
			avail_s2 <= avail_d;
		end
		if (cmd.apply_rel) begin
			rsp_q.granted    <= rel_ok;
			rsp_q.grant_node <= req_q.release_node;
			rsp_q.grant_mask <= '0;
			rsp_q.free_count <= '0;
		end else if (cmd.eval && (qualify || last_node)) begin
			rsp_q.granted    <= qualify;
			rsp_q.grant_node <= qualify ? node_q : '0;
			rsp_q.grant_mask <= qualify ? mask_d : '0;
			rsp_q.free_count <= blocked ? '0 : avail_s2;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

### rtl/first_fit_core_node_allocator.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// first_fit_core_node_allocator: first-fit core and accelerator allocator
// Allocates lowest free cores on the first node that fits; frees on release.
// -----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Its result comes
// back exactly once, on rsp with done high for one cycle, and must be captured
// then: there is no backpressure. A release shows its result in the cycle busy
// drops. An allocate examines 1 up to 3 nodes, and each node passes through
// the shared three-step scan datapath (count free cores per byte chunk,
// prefix-sum the chunks, compare and pick the lowest free cores). done rises
// in the cycle busy falls. cfg_we/cfg_wdata set cores_per_node (reset 64,
// values above 64 saturate) and must only be written while the block is idle.
// Both busy stores clear at reset; no clearing pass is needed.
// -----------------------------------------------------------------------------
module first_fit_core_node_allocator (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  ffa_pkg::ffa_req_t         req,
	output logic                      done,
	output ffa_pkg::ffa_rsp_t         rsp,
	input  logic                      cfg_we,
	input  logic [ffa_pkg::CNT_W-1:0] cfg_wdata
);
	import ffa_pkg::*;

	ffa_cmd_t    cmd;
	ffa_status_t status;

	// sequencer: one state per scan step, controller only sees qualify/last
	ffa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (req.opcode),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// stores, counting logic and result register
	ffa_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.status    (status),
		.done      (done),
		.rsp       (rsp)
	);

endmodule

### rtl/ffa_checker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ffa_checker: port-level checks for the allocator
// Result timing against busy, and result field consistency.
// -----------------------------------------------------------------------------
module ffa_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input ffa_pkg::ffa_rsp_t rsp
);
	import ffa_pkg::*;

	// a taken transaction makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accept");

	// result only once the sequencer is back to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result while busy");

	// finishing a transaction always yields a result
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("transaction ended without result");

	// denied results carry no cores
	a_deny_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.granted) |-> (rsp.grant_mask == '0))
		else $error("denied result carries a mask");

	// never more cores granted than were free
	a_mask_count: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($countones(rsp.grant_mask) <= int'(rsp.free_count)))
		else $error("grant mask exceeds free count");

endmodule

bind first_fit_core_node_allocator ffa_checker u_ffa_checker (.*);

### verif/first_fit_core_node_allocator_checker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// first_fit_core_node_allocator_checker: grant predictor and result checker
// Watches the request, response and config channels. It keeps its own core
// and accelerator maps, predicts each grant, and compares the responses in order.
// -----------------------------------------------------------------------------
module first_fit_core_node_allocator_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  ffa_pkg::ffa_req_t         req,
	input  logic                      done,
	input  ffa_pkg::ffa_rsp_t         rsp,
	input  logic                      cfg_we,
	input  logic [ffa_pkg::CNT_W-1:0] cfg_wdata,
	output int                        outstanding,
	output int                        mismatches,
	output int                        alloc_grants
);
	import ffa_pkg::*;

	logic [MAP_W-1:0] core_map [NODES];
	logic [NODES-1:0] accel_taken;
	logic [CNT_W-1:0] cores_cfg;
	ffa_rsp_t         grant_q [$];
	ffa_rsp_t         want;
	ffa_rsp_t         pred;
	int               errs;
	int               grant_cnt;
	int               rsp_idx;

	// Applies one transaction to the shadow maps and returns its response.
	function automatic ffa_rsp_t next_grant(input ffa_req_t r);
		ffa_rsp_t         res;
		logic [MAP_W-1:0] usable;
		logic [MAP_W-1:0] freemap;
		logic [MAP_W-1:0] pick;
		int unsigned      eff;
		int unsigned      avail;
		int unsigned      left;
		res = '0;
		if (r.opcode == OP_RELEASE) begin
			res.grant_node = r.release_node;
			if (r.release_node < NODES) begin
				core_map[r.release_node] &= ~r.release_mask;
				if (r.release_accel)
					accel_taken[r.release_node] = 1'b0;
				res.granted = 1'b1;
			end
		end else begin
			eff = (cores_cfg > MAX_CORES) ? MAX_CORES : cores_cfg;
			usable = (eff >= MAP_W) ? '1 : (MAP_W'(1) << eff) - MAP_W'(1);
			for (int n = 0; n < NODES; n++) begin
				if (r.req_accel && accel_taken[n]) begin
					res.free_count = '0;
					continue;
				end
				freemap = ~core_map[n] & usable;
				avail = $countones(freemap);
				res.free_count = CNT_W'(avail);
				if (r.req_cores != 0 && avail >= r.req_cores) begin
					pick = '0;
					left = r.req_cores;
					for (int b = 0; b < MAP_W; b++) begin
						if (freemap[b] && left != 0) begin
							pick[b] = 1'b1;
							left--;
						end
					end
					core_map[n] |= pick;
					if (r.req_accel)
						accel_taken[n] = 1'b1;
					res.granted = 1'b1;
					res.grant_node = NODE_W'(n);
					res.grant_mask = pick;
					break;
				end
			end
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < NODES; n++)
				core_map[n] = '0;
			accel_taken = '0;
			cores_cfg = CNT_W'(64);
			grant_q.delete();
			errs = 0;
			grant_cnt = 0;
			rsp_idx = 0;
			outstanding <= 0;
			mismatches <= 0;
			alloc_grants <= 0;
		end else begin
			// retire first: a response and the next accept can share an edge
			if (done) begin
				if (grant_q.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("[%0t] response with no transaction pending: %p", $time, rsp);
				end else begin
					want = grant_q.pop_front();
					if (rsp.granted !== want.granted || rsp.grant_node !== want.grant_node ||
							rsp.grant_mask !== want.grant_mask ||
							rsp.free_count !== want.free_count) begin
						errs++;
						if (errs <= 10) begin
							$display("[%0t] response %0d mismatch", $time, rsp_idx);
							$display("  expected granted=%0b node=%0d mask=%h free=%0d",
								want.granted, want.grant_node, want.grant_mask,
								want.free_count);
							$display("  actual   granted=%0b node=%0d mask=%h free=%0d",
								rsp.granted, rsp.grant_node, rsp.grant_mask,
								rsp.free_count);
						end
					end
				end
				rsp_idx++;
			end
			if (cfg_we)
				cores_cfg = cfg_wdata;
			if (start && !busy) begin
				pred = next_grant(req);
				if (req.opcode == OP_ALLOC && pred.granted)
					grant_cnt++;
				grant_q.push_back(pred);
			end
			outstanding <= grant_q.size();
			mismatches <= errs;
			alloc_grants <= grant_cnt;
		end
	end

endmodule

### verif/tb_first_fit_core_node_allocator.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_first_fit_core_node_allocator: testbench top for the node allocator
// Drives directed and random allocate/release transactions under several
// cores_per_node settings and idle mixes; the checker predicts and compares.
// -----------------------------------------------------------------------------
module tb_first_fit_core_node_allocator;
	import ffa_pkg::*;

	// cycles with no accept, no response and no config write before giving up;
	// sender gaps between items are short geometric runs
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SEG_ITEMS      = 110;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	ffa_req_t         req;
	logic             done;
	ffa_rsp_t         rsp;
	logic             cfg_we;
	logic [CNT_W-1:0] cfg_wdata;

	int               outstanding;
	int               mismatches;
	int               alloc_grants;

	int               idle_pct;     // chance in 100 that the sender idles a cycle
	int               n_alloc;
	int               n_release;
	int               n_cfg;
	int               quiet;
	logic [CNT_W-1:0] cores_now;    // last value written to cores_per_node
	logic [CNT_W-1:0] cfg_plan [9];

	first_fit_core_node_allocator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	first_fit_core_node_allocator_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req          (req),
		.done         (done),
		.rsp          (rsp),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.outstanding  (outstanding),
		.mismatches   (mismatches),
		.alloc_grants (alloc_grants)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Random transaction shaped so the maps keep filling and draining: mostly
	// small requests against the usable core count, frequent whole-node frees,
	// plus zero, oversized and missing-node cases as noise.
	function automatic ffa_req_t random_item(input int eff);
		ffa_req_t r;
		int       pick;
		int       hi;
		hi = (eff < 1) ? 1 : eff;
		r.opcode = ($urandom_range(99) < 55) ? OP_ALLOC : OP_RELEASE;
		r.req_accel = ($urandom_range(99) < 30);
		r.release_node = ($urandom_range(9) == 0) ? NODE_W'(3) : NODE_W'($urandom_range(NODES - 1));
		r.release_accel = 1'($urandom_range(1));
		pick = $urandom_range(99);
		if (pick < 5)
			r.req_cores = '0;
		else if (pick < 10)
			r.req_cores = CNT_W'($urandom_range(127, 65));
		else if (pick < 18)
			r.req_cores = CNT_W'(hi);
		else if (pick < 40)
			r.req_cores = CNT_W'($urandom_range(hi, 1));
		else
			r.req_cores = CNT_W'($urandom_range((hi > 12) ? 12 : hi, 1));
		pick = $urandom_range(99);
		if (pick < 40)
			r.release_mask = '1;
		else if (pick < 65)
			r.release_mask = {$urandom, $urandom};
		else if (pick < 85)
			r.release_mask = {$urandom, $urandom} &
				((MAP_W'(1) << $urandom_range(63, 1)) - MAP_W'(1));
		else if (pick < 95)
			r.release_mask = MAP_W'(1) << $urandom_range(63);
		else
			r.release_mask = '0;
		return r;
	endfunction

	// Offer one transaction and hold it until accepted, then maybe idle.
	task automatic send_item(input ffa_req_t r);
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (r.opcode == OP_ALLOC)
			n_alloc++;
		else
			n_release++;
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct)
				@(posedge clk);
		end
	endtask

	task automatic do_alloc(input int cores, input logic accel);
		ffa_req_t r;
		r = random_item(MAX_CORES);
		r.opcode = OP_ALLOC;
		r.req_cores = CNT_W'(cores);
		r.req_accel = accel;
		send_item(r);
	endtask

	task automatic do_release(input logic [NODE_W-1:0] node, input logic [MAP_W-1:0] mask,
			input logic accel);
		ffa_req_t r;
		r = random_item(MAX_CORES);
		r.opcode = OP_RELEASE;
		r.release_node = node;
		r.release_mask = mask;
		r.release_accel = accel;
		send_item(r);
	endtask

	// Stop offering and wait until every response is back. The checker count
	// is registered, so look at it only once the last accept has been clocked in.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// cores_per_node only changes with the block idle
	task automatic write_cores(input logic [CNT_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cores_now = v;
		n_cfg++;
	endtask

	// Watchdog: any accept, response or config write counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || cfg_we)
			quiet <= 0;
		else if (quiet >= WATCHDOG_LIMIT) begin
			$display("watchdog: no progress for %0d cycles, %0d responses pending",
				WATCHDOG_LIMIT, outstanding);
			$display("CHECK FAILED");
			$finish;
		end else
			quiet <= quiet + 1;
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		quiet = 0;
		n_alloc = 0;
		n_release = 0;
		n_cfg = 0;
		cores_now = CNT_W'(64);
		idle_pct = 16;
		cfg_plan = '{CNT_W'(64), CNT_W'(1), CNT_W'(127), CNT_W'(8), CNT_W'(0),
			CNT_W'(64), CNT_W'($urandom_range(63, 2)), CNT_W'(3), CNT_W'(64)};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed: reset setting of 64 cores per node
		do_alloc(0, 1'b0);                          // zero cores: denied
		do_alloc(64, 1'b1);                         // node 0 full, accel taken
		do_alloc(1, 1'b1);                          // node 0 accel busy, lands on node 1
		do_alloc(65, 1'b0);                         // beyond any node
		do_alloc(127, 1'b1);
		do_alloc(64, 1'b0);                         // node 1 short by one, node 2 fits
		do_alloc(63, 1'b0);                         // fills the rest of node 1
		do_alloc(1, 1'b0);                          // everything busy: denied
		do_release(2'd3, '1, 1'b1);                 // missing node
		do_release(2'd0, 64'hFFFF_FFFF_0000_0000, 1'b0);
		do_release(2'd1, '0, 1'b1);                 // accelerator only
		do_release(2'd2, 64'h5555_5555_5555_5555, 1'b0);
		do_alloc(40, 1'b1);                         // denied, last node reports 32
		do_alloc(32, 1'b0);                         // upper half of node 0
		do_release(2'd0, '1, 1'b1);
		do_release(2'd1, '1, 1'b1);
		do_release(2'd2, '1, 1'b1);

		// no usable cores
		write_cores(CNT_W'(0));
		do_alloc(1, 1'b0);
		do_alloc(0, 1'b1);
		// oversized setting saturates to the full map
		write_cores(CNT_W'(127));
		do_alloc(64, 1'b0);
		// busy bits above a lowered setting are never counted or granted
		write_cores(CNT_W'(8));
		do_alloc(1, 1'b0);
		do_release(2'd0, 64'h0000_0000_0000_00FF, 1'b0);
		do_alloc(8, 1'b1);
		write_cores(CNT_W'(1));
		do_alloc(1, 1'b1);

		// --- random: three idle mixes, three core settings each
		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 16 : (ph == 1) ? 55 : 0;
			for (int s = 0; s < 3; s++) begin
				write_cores(cfg_plan[ph * 3 + s]);
				repeat (SEG_ITEMS)
					send_item(random_item((cores_now > MAX_CORES) ? MAX_CORES : cores_now));
			end
		end

		drain();
		repeat (12) @(posedge clk);
		$display("Covered %0d transactions: %0d allocates (%0d granted), %0d releases",
			n_alloc + n_release, n_alloc, alloc_grants, n_release);
		$display("over %0d cores_per_node settings and three idle mixes, %0d mismatches",
			n_cfg, mismatches);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
